@@ design/baro_pkg.sv @@
// shared types, widths and helpers of the barometric compensation pipeline
`default_nettype none

package baro_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CAL_W      = 16;
  localparam int RAW_W      = 24;
  localparam int TEMP_W     = 19;
  localparam int POUT_W     = 32;

  // internal widths, sized from the value ranges
  localparam int DT_W   = 25;  // raw temperature minus reference
  localparam int PROD_W = 42;  // 17 bit unsigned coefficient times dt
  localparam int DSQ_W  = 50;  // dt squared
  localparam int SO_W   = 38;  // first-order sens and off
  localparam int D_W    = 19;  // first-order temperature minus 20.00 C
  localparam int D2_W   = 38;
  localparam int E_W    = 20;
  localparam int EE_W   = 40;
  localparam int TI_W   = 18;
  localparam int TT_W   = 21;
  localparam int CORR_W = 41;  // corrected sens and off
  localparam int LO_W   = 20;
  localparam int HI_W   = CORR_W - LO_W;
  localparam int PPL_W  = RAW_W + LO_W;
  localparam int PPH_W  = RAW_W + 1 + HI_W;
  localparam int FULL_W = 66;
  localparam int Q_W    = 46;
  localparam int DIV_W  = 72;

  localparam int T_REF     = 2000;
  localparam int T_VLOW_OF = 3500;  // -15.00 C relative to 20.00 C

  localparam int SH_SENS_2B = 7;
  localparam int SH_SENS_30 = 8;
  localparam int SH_OFF_2B  = 6;
  localparam int SH_OFF_30  = 7;
  localparam int SH_TEMP    = 23;
  localparam int SH_TI_2B   = 35;
  localparam int SH_TI_LO   = 33;
  localparam int SH_TI_HI   = 37;
  localparam int SH_PROD    = 21;
  localparam int SH_P_2B    = 15;
  localparam int SH_P_30    = 13;

  localparam logic signed [DIV_W-1:0] P_MAX = DIV_W'(64'sd2147483647);
  localparam logic signed [DIV_W-1:0] P_MIN = -P_MAX - DIV_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODEL_SELECT = 3'd0,
    REG_SENS_BASE    = 3'd1,
    REG_OFF_BASE     = 3'd2,
    REG_SENS_TC      = 3'd3,
    REG_OFF_TC       = 3'd4,
    REG_REF_TEMP     = 3'd5,
    REG_TEMP_COEFF   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic             model_select;
    logic [CAL_W-1:0] sens_base;
    logic [CAL_W-1:0] off_base;
    logic [CAL_W-1:0] sens_tc;
    logic [CAL_W-1:0] off_tc;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_coeff;
  } baro_cfg_t;

  // hand-off from the correction stages to the pressure stages
  typedef struct packed {
    logic                     vld;
    logic [RAW_W-1:0]         press;
    logic signed [TEMP_W-1:0] temp;
    logic signed [CORR_W-1:0] off;
    logic signed [CORR_W-1:0] sens;
  } baro_comp_t;

  // signed divide by 2**k, truncating toward zero
  function automatic logic signed [DIV_W-1:0] sdiv_pow2(input logic signed [DIV_W-1:0] x,
                                                        input int unsigned k);
    logic signed [DIV_W-1:0] bias;
    bias = (DIV_W'(1) << k) - DIV_W'(1);
    if (x[DIV_W-1]) begin
      sdiv_pow2 = (x + bias) >>> k;
    end else begin
      sdiv_pow2 = x >>> k;
    end
  endfunction

endpackage

`default_nettype wire

@@ design/baro_regs.sv @@
// calibration and model select registers
`default_nettype none

module baro_regs
  import baro_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output baro_cfg_t                  cfg
);

  baro_cfg_t cfg_r;
  baro_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODEL_SELECT: cfg_nxt.model_select = cfg_wdata[0];
        REG_SENS_BASE:    cfg_nxt.sens_base    = cfg_wdata;
        REG_OFF_BASE:     cfg_nxt.off_base     = cfg_wdata;
        REG_SENS_TC:      cfg_nxt.sens_tc      = cfg_wdata;
        REG_OFF_TC:       cfg_nxt.off_tc       = cfg_wdata;
        REG_REF_TEMP:     cfg_nxt.ref_temp     = cfg_wdata;
        REG_TEMP_COEFF:   cfg_nxt.temp_coeff   = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ design/baro_corr.sv @@
// temperature and first/second-order sens and off, six pipeline stages
`default_nettype none

module baro_corr
  import baro_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  baro_cfg_t             cfg,
  input  wire logic             in_vld,
  input  wire logic [RAW_W-1:0] in_press,
  input  wire logic [RAW_W-1:0] in_traw,
  output baro_comp_t            comp
);

  logic two_bar;
  assign two_bar = cfg.model_select;

  // stage 1: dt
  logic                    v1_r;
  logic [RAW_W-1:0]        press1_r;
  logic signed [DT_W-1:0]  dt1_r;
  logic signed [DT_W-1:0]  dt1_nxt;

  assign dt1_nxt = $signed({1'b0, in_traw}) - $signed({1'b0, cfg.ref_temp, 8'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
    press1_r <= in_press;
    dt1_r    <= dt1_nxt;
  end

  // stage 2: products with dt
  logic                     v2_r;
  logic [RAW_W-1:0]         press2_r;
  logic signed [PROD_W-1:0] psens2_r;
  logic signed [PROD_W-1:0] poff2_r;
  logic signed [PROD_W-1:0] ptemp2_r;
  logic signed [DSQ_W-1:0]  dsq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    press2_r <= press1_r;
    psens2_r <= PROD_W'($signed({1'b0, cfg.sens_tc})) * PROD_W'(dt1_r);
    poff2_r  <= PROD_W'($signed({1'b0, cfg.off_tc})) * PROD_W'(dt1_r);
    ptemp2_r <= PROD_W'($signed({1'b0, cfg.temp_coeff})) * PROD_W'(dt1_r);
    dsq2_r   <= DSQ_W'(dt1_r) * DSQ_W'(dt1_r);
  end

  // stage 3: first-order sens, off and temperature
  logic                    v3_r;
  logic [RAW_W-1:0]        press3_r;
  logic signed [SO_W-1:0]  sens3_r;
  logic signed [SO_W-1:0]  off3_r;
  logic signed [D_W-1:0]   d3_r;
  logic signed [DSQ_W-1:0] dsq3_r;
  logic signed [SO_W-1:0]  sens_b;
  logic signed [SO_W-1:0]  off_b;
  logic signed [SO_W-1:0]  sens_q;
  logic signed [SO_W-1:0]  off_q;
  logic signed [SO_W-1:0]  sens3_nxt;
  logic signed [SO_W-1:0]  off3_nxt;
  logic signed [D_W-1:0]   d3_nxt;

  always_comb begin
    if (two_bar) begin
      sens_b = SO_W'({cfg.sens_base, 16'd0});
      off_b  = SO_W'({cfg.off_base, 17'd0});
      sens_q = SO_W'(sdiv_pow2(DIV_W'(psens2_r), SH_SENS_2B));
      off_q  = SO_W'(sdiv_pow2(DIV_W'(poff2_r), SH_OFF_2B));
    end else begin
      sens_b = SO_W'({cfg.sens_base, 15'd0});
      off_b  = SO_W'({cfg.off_base, 16'd0});
      sens_q = SO_W'(sdiv_pow2(DIV_W'(psens2_r), SH_SENS_30));
      off_q  = SO_W'(sdiv_pow2(DIV_W'(poff2_r), SH_OFF_30));
    end
    sens3_nxt = sens_b + sens_q;
    off3_nxt  = off_b + off_q;
    d3_nxt    = D_W'(sdiv_pow2(DIV_W'(ptemp2_r), SH_TEMP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    press3_r <= press2_r;
    sens3_r  <= sens3_nxt;
    off3_r   <= off3_nxt;
    d3_r     <= d3_nxt;
    dsq3_r   <= dsq2_r;
  end

  // stage 4: squares, range flags and temperature correction
  logic                    v4_r;
  logic [RAW_W-1:0]        press4_r;
  logic signed [SO_W-1:0]  sens4_r;
  logic signed [SO_W-1:0]  off4_r;
  logic signed [D_W-1:0]   d4_r;
  logic signed [D2_W-1:0]  d2_4_r;
  logic signed [EE_W-1:0]  ee4_r;
  logic                    low4_r;
  logic                    vlow4_r;
  logic [TI_W-1:0]         ti4_r;
  logic signed [E_W-1:0]   e4;
  logic [DSQ_W+3:0]        dsqx;
  logic [TI_W-1:0]         ti4_nxt;
  logic                    low4_nxt;
  logic                    vlow4_nxt;

  assign e4        = E_W'(d3_r) + E_W'(T_VLOW_OF);
  assign low4_nxt  = d3_r[D_W-1];
  assign vlow4_nxt = d3_r < -D_W'(T_VLOW_OF);

  always_comb begin
    dsqx = (DSQ_W+4)'(unsigned'(dsq3_r));
    if (two_bar) begin
      ti4_nxt = low4_nxt ? TI_W'(((dsqx << 3) + (dsqx << 1) + dsqx) >> SH_TI_2B) : '0;
    end else if (low4_nxt) begin
      ti4_nxt = TI_W'(((dsqx << 1) + dsqx) >> SH_TI_LO);
    end else begin
      ti4_nxt = TI_W'((dsqx << 1) >> SH_TI_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    press4_r <= press3_r;
    sens4_r  <= sens3_r;
    off4_r   <= off3_r;
    d4_r     <= d3_r;
    d2_4_r   <= D2_W'(d3_r) * D2_W'(d3_r);
    ee4_r    <= EE_W'(e4) * EE_W'(e4);
    low4_r   <= low4_nxt;
    vlow4_r  <= vlow4_nxt;
    ti4_r    <= ti4_nxt;
  end

  // stage 5: offset and sensitivity corrections, final temperature
  logic                     v5_r;
  logic [RAW_W-1:0]         press5_r;
  logic signed [SO_W-1:0]   sens5_r;
  logic signed [SO_W-1:0]   off5_r;
  logic signed [CORR_W-1:0] offi5_r;
  logic signed [CORR_W-1:0] sensi5_r;
  logic signed [TEMP_W-1:0] temp5_r;
  logic signed [CORR_W-1:0] d2w;
  logic signed [CORR_W-1:0] eew;
  logic signed [CORR_W-1:0] offi_nxt;
  logic signed [CORR_W-1:0] sensi_nxt;
  logic signed [TT_W-1:0]   tt_nxt;

  // squares are never negative, so the divides are plain shifts
  always_comb begin
    d2w = CORR_W'(d2_4_r);
    eew = CORR_W'(ee4_r);
    if (two_bar) begin
      offi_nxt  = low4_r ? (((d2w <<< 5) - d2w) >>> 3) : '0;
      sensi_nxt = low4_r ? (((d2w <<< 6) - d2w) >>> 5) : '0;
    end else if (low4_r) begin
      offi_nxt  = ((d2w <<< 1) + d2w) >>> 1;
      sensi_nxt = ((d2w <<< 2) + d2w) >>> 3;
      if (vlow4_r) begin
        offi_nxt  = offi_nxt + ((eew <<< 3) - eew);
        sensi_nxt = sensi_nxt + (eew <<< 2);
      end
    end else begin
      offi_nxt  = d2w >>> 4;
      sensi_nxt = '0;
    end
    tt_nxt = TT_W'(T_REF) + TT_W'(d4_r) - $signed({3'b000, ti4_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    press5_r <= press4_r;
    sens5_r  <= sens4_r;
    off5_r   <= off4_r;
    offi5_r  <= offi_nxt;
    sensi5_r <= sensi_nxt;
    temp5_r  <= tt_nxt[TEMP_W-1:0];
  end

  // stage 6: apply corrections
  baro_comp_t comp_r;
  baro_comp_t comp_nxt;

  always_comb begin
    comp_nxt.vld   = v5_r;
    comp_nxt.press = press5_r;
    comp_nxt.temp  = temp5_r;
    comp_nxt.off   = CORR_W'(off5_r) - offi5_r;
    comp_nxt.sens  = CORR_W'(sens5_r) - sensi5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_r.vld <= 1'b0;
    end else begin
      comp_r.vld <= comp_nxt.vld;
    end
    comp_r.press <= comp_nxt.press;
    comp_r.temp  <= comp_nxt.temp;
    comp_r.off   <= comp_nxt.off;
    comp_r.sens  <= comp_nxt.sens;
  end

  assign comp = comp_r;

endmodule

`default_nettype wire

@@ design/baro_press.sv @@
// pressure product, scaling and saturation, four pipeline stages
`default_nettype none

module baro_press
  import baro_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  baro_cfg_t               cfg,
  input  baro_comp_t              comp,
  output logic                    out_vld,
  output logic signed [TEMP_W-1:0] out_temp,
  output logic signed [POUT_W-1:0] out_press
);

  // stage 7: two partial products of raw pressure times sens
  logic                     v7_r;
  logic signed [TEMP_W-1:0] temp7_r;
  logic signed [CORR_W-1:0] off7_r;
  logic [PPL_W-1:0]         ppl7_r;
  logic signed [PPH_W-1:0]  pph7_r;
  logic [LO_W-1:0]          sens_lo;
  logic signed [HI_W-1:0]   sens_hi;

  assign sens_lo = comp.sens[LO_W-1:0];
  assign sens_hi = comp.sens[CORR_W-1:LO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= comp.vld;
    end
    temp7_r <= comp.temp;
    off7_r  <= comp.off;
    ppl7_r  <= PPL_W'(comp.press) * PPL_W'(sens_lo);
    pph7_r  <= PPH_W'($signed({1'b0, comp.press})) * PPH_W'(sens_hi);
  end

  // stage 8: combine partial products
  logic                     v8_r;
  logic signed [TEMP_W-1:0] temp8_r;
  logic signed [CORR_W-1:0] off8_r;
  logic signed [FULL_W-1:0] full8_r;
  logic signed [FULL_W-1:0] full8_nxt;

  assign full8_nxt = (FULL_W'(pph7_r) <<< LO_W) + $signed({{(FULL_W-PPL_W){1'b0}}, ppl7_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
    temp8_r <= temp7_r;
    off8_r  <= off7_r;
    full8_r <= full8_nxt;
  end

  // stage 9: scale product, remove offset
  logic                     v9_r;
  logic signed [TEMP_W-1:0] temp9_r;
  logic signed [Q_W-1:0]    p9_r;
  logic signed [Q_W-1:0]    p9_nxt;

  assign p9_nxt = Q_W'(sdiv_pow2(DIV_W'(full8_r), SH_PROD)) - Q_W'(off8_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= v8_r;
    end
    temp9_r <= temp8_r;
    p9_r    <= p9_nxt;
  end

  // stage 10: output scaling and clamp to 32 bits
  logic                     v10_r;
  logic signed [TEMP_W-1:0] temp10_r;
  logic signed [POUT_W-1:0] p10_r;
  logic signed [DIV_W-1:0]  pd;
  logic signed [POUT_W-1:0] p10_nxt;

  always_comb begin
    pd = sdiv_pow2(DIV_W'(p9_r), cfg.model_select ? SH_P_2B : SH_P_30);
    if (pd > P_MAX) begin
      p10_nxt = P_MAX[POUT_W-1:0];
    end else if (pd < P_MIN) begin
      p10_nxt = P_MIN[POUT_W-1:0];
    end else begin
      p10_nxt = pd[POUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else begin
      v10_r <= v9_r;
    end
    temp10_r <= temp9_r;
    p10_r    <= p10_nxt;
  end

  assign out_vld   = v10_r;
  assign out_temp  = temp10_r;
  assign out_press = p10_r;

endmodule

`default_nettype wire

@@ design/baro_sensor_second_order_compensation_top.sv @@
// top level of the second-order barometric sensor compensation pipeline
//
// usage:
//   - load the model select and six calibration words through cfg_we,
//     cfg_index and cfg_wdata while no request is in flight; each write
//     takes effect at the clock edge where cfg_we is high
//   - a request is taken at each edge where start is high and busy is low;
//     busy stays low, so a new raw pressure/temperature pair can be given
//     in every cycle
//   - the result shows on out_temperature_out and out_pressure_out with
//     out_valid high for one cycle, after the request has passed through
//     the ten register stages (dt, products, first order terms, squares,
//     corrections, apply, two pressure partial products, combine, scale,
//     clamp)
//   - throughput is one request per cycle, in order, one result each
//   - the receiver has no backpressure; results must be taken as they come
//   - synchronous reset (rst_n low) clears the calibration registers and
//     the valid bits, dropping all requests in flight
`default_nettype none

module baro_sensor_second_order_compensation_top
  import baro_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [RAW_W-1:0]       in_pressure_count,
  input  wire logic [RAW_W-1:0]       in_temperature_count,
  output logic                        out_valid,
  output logic signed [TEMP_W-1:0]    out_temperature_out,
  output logic signed [POUT_W-1:0]    out_pressure_out
);

  baro_cfg_t  cfg;
  baro_comp_t comp;
  logic       req;

  // fully pipelined, a request is taken every cycle
  assign busy = 1'b0;
  assign req  = start & ~busy;

  baro_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  baro_corr u_corr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_vld   (req),
    .in_press (in_pressure_count),
    .in_traw  (in_temperature_count),
    .comp     (comp)
  );

  baro_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .comp      (comp),
    .out_vld   (out_valid),
    .out_temp  (out_temperature_out),
    .out_press (out_pressure_out)
  );

endmodule

`default_nettype wire

@@ verif/baro_sensor_second_order_compensation_top_tb.sv @@
// testbench for the second-order barometric compensation pipeline
`timescale 1ns / 1ps

module baro_sensor_second_order_compensation_top_tb;
  import baro_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // outside the register list
  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
  localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 80;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic signed [POUT_W-1:0] pressure;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [RAW_W-1:0] in_pressure_count = '0;
  logic [RAW_W-1:0] in_temperature_count = '0;
  logic out_valid;
  logic signed [TEMP_W-1:0] out_temperature_out;
  logic signed [POUT_W-1:0] out_pressure_out;

  baro_cfg_t cal_shadow = '0;
  reading_t expected_readings[$];
  reading_t head;
  int sent_count = 0;
  int done_count = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  baro_sensor_second_order_compensation_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .start                (start),
    .busy                 (busy),
    .in_pressure_count    (in_pressure_count),
    .in_temperature_count (in_temperature_count),
    .out_valid            (out_valid),
    .out_temperature_out  (out_temperature_out),
    .out_pressure_out     (out_pressure_out)
  );

  always #4 clk = ~clk;

  // expected temperature and pressure for one raw pair
  function automatic reading_t compensate(input baro_cfg_t c, input logic [RAW_W-1:0] pc,
                                          input logic [RAW_W-1:0] tc);
    longint press, traw, c1, c2, c3, c4, c5, c6;
    longint dt, sens, off, temp, d, d2, dsq, e, p;
    longint ti, offi, sensi;
    reading_t r;
    press = pc;
    traw = tc;
    c1 = c.sens_base;
    c2 = c.off_base;
    c3 = c.sens_tc;
    c4 = c.off_tc;
    c5 = c.ref_temp;
    c6 = c.temp_coeff;
    ti = 0;
    offi = 0;
    sensi = 0;
    dt = traw - c5 * 256;
    if (c.model_select) begin
      sens = c1 * 65536 + (c3 * dt) / 128;
      off = c2 * 131072 + (c4 * dt) / 64;
    end else begin
      sens = c1 * 32768 + (c3 * dt) / 256;
      off = c2 * 65536 + (c4 * dt) / 128;
    end
    temp = 2000 + (dt * c6) / 8388608;
    d = temp - 2000;
    d2 = d * d;
    dsq = dt * dt;
    if (c.model_select) begin
      if (temp < 2000) begin
        ti = (11 * dsq) / 64'sd34359738368;
        offi = (31 * d2) / 8;
        sensi = (63 * d2) / 32;
      end
    end else if (temp < 2000) begin
      ti = (3 * dsq) / 64'sd8589934592;
      offi = (3 * d2) / 2;
      sensi = (5 * d2) / 8;
      if (temp < -1500) begin
        e = temp + 1500;
        offi += 7 * e * e;
        sensi += 4 * e * e;
      end
    end else begin
      ti = (2 * dsq) / 64'sd137438953472;
      offi = d2 / 16;
    end
    off -= offi;
    sens -= sensi;
    temp -= ti;
    p = (press * sens) / 2097152 - off;
    p = c.model_select ? p / 32768 : p / 8192;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    r.temperature = temp[TEMP_W-1:0];
    r.pressure = p[POUT_W-1:0];
    return r;
  endfunction

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  // result checking, write tracking and request capture
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_readings.size() == 0) begin
          report_failure($sformatf("result with nothing pending: temperature %0d pressure %0d",
                                   out_temperature_out, out_pressure_out));
        end else begin
          head = expected_readings.pop_front();
          if (out_temperature_out !== head.temperature)
            report_failure($sformatf("temperature_out: expected %0d got %0d",
                                     head.temperature, out_temperature_out));
          if (out_pressure_out !== head.pressure)
            report_failure($sformatf("pressure_out: expected %0d got %0d",
                                     head.pressure, out_pressure_out));
          done_count++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MODEL_SELECT: cal_shadow.model_select = cfg_wdata[0];
          REG_SENS_BASE:    cal_shadow.sens_base = cfg_wdata;
          REG_OFF_BASE:     cal_shadow.off_base = cfg_wdata;
          REG_SENS_TC:      cal_shadow.sens_tc = cfg_wdata;
          REG_OFF_TC:       cal_shadow.off_tc = cfg_wdata;
          REG_REF_TEMP:     cal_shadow.ref_temp = cfg_wdata;
          REG_TEMP_COEFF:   cal_shadow.temp_coeff = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy)
        expected_readings.push_back(compensate(cal_shadow, in_pressure_count,
                                               in_temperature_count));
    end
  end

  // watchdog on cycles without any traffic
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // an idle gap comes before about 4 in 100 requests
  task automatic send_sample(input logic [RAW_W-1:0] pc, input logic [RAW_W-1:0] tc);
    if (gaps_on && $urandom_range(0, 99) < 4) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_pressure_count <= pc;
    in_temperature_count <= tc;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (done_count < sent_count) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_calibration(input baro_cfg_t c);
    wait_idle();
    // upper bits of the model select write must be ignored
    write_reg(REG_MODEL_SELECT, {15'($urandom), c.model_select});
    write_reg(REG_SENS_BASE, c.sens_base);
    write_reg(REG_OFF_BASE, c.off_base);
    write_reg(REG_SENS_TC, c.sens_tc);
    write_reg(REG_OFF_TC, c.off_tc);
    write_reg(REG_REF_TEMP, c.ref_temp);
    write_reg(REG_TEMP_COEFF, c.temp_coeff);
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // raw temperature that puts the first-order offset from 20.00 C near d_target
  function automatic logic [RAW_W-1:0] temp_count_for(input baro_cfg_t c, input longint d_target,
                                                      input longint jitter);
    longint dt, traw;
    dt = (c.temp_coeff == 0) ? 0 : (d_target * 8388608) / longint'(c.temp_coeff);
    traw = longint'(c.ref_temp) * 256 + dt + jitter;
    if (traw < 0) traw = 0;
    if (traw > longint'(RAW_MAX)) traw = longint'(RAW_MAX);
    return traw[RAW_W-1:0];
  endfunction

  function automatic logic [RAW_W-1:0] random_temp_count(input baro_cfg_t c);
    int unsigned pick;
    longint k;
    pick = $urandom_range(0, 9);
    if (pick < 3) return RAW_W'($urandom);
    if (pick < 7) begin
      // around the low and very-low thresholds
      case ($urandom_range(0, 3))
        0: k = 0;
        1: k = -1;
        2: k = -3500;
        default: k = -3501;
      endcase
      return temp_count_for(c, k, longint'($urandom_range(0, 8)) - 4);
    end
    k = longint'($urandom_range(0, 300000)) - 150000;
    return temp_count_for(c, k, 0);
  endfunction

  function automatic logic [RAW_W-1:0] random_pressure_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RAW_MAX;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [CAL_W-1:0] random_cal_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CAL_MAX;
      default: return CAL_W'($urandom);
    endcase
  endfunction

  function automatic baro_cfg_t typical_calibration(input logic sel);
    baro_cfg_t c;
    c.model_select = sel;
    c.sens_base = 16'd34982;
    c.off_base = 16'd36352;
    c.sens_tc = 16'd20328;
    c.off_tc = 16'd22354;
    c.ref_temp = 16'd26646;
    c.temp_coeff = 16'd26146;
    return c;
  endfunction

  // all registers still at their reset value
  task automatic test_reset_values();
    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(24'h800000, 24'h123456);
  endtask

  task automatic test_30bar_directed();
    baro_cfg_t c;
    c = typical_calibration(1'b0);
    load_calibration(c);
    send_sample(24'd4958179, temp_count_for(c, 1000, 0));
    send_sample(24'd4958179, temp_count_for(c, 0, 0));
    send_sample(24'd4958179, temp_count_for(c, -1, -1));
    send_sample(24'd4958179, temp_count_for(c, -3000, 0));
    send_sample(24'd4958179, temp_count_for(c, -3500, 0));
    send_sample(24'd4958179, temp_count_for(c, -3501, -1));
    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
  endtask

  task automatic test_2bar_directed();
    baro_cfg_t c;
    c = typical_calibration(1'b1);
    load_calibration(c);
    send_sample(24'd6465444, temp_count_for(c, 1000, 0));
    send_sample(24'd6465444, temp_count_for(c, 0, 0));
    send_sample(24'd6465444, temp_count_for(c, -1, -1));
    send_sample(24'd6465444, temp_count_for(c, -5000, 0));
    send_sample(RAW_MAX, '0);
  endtask

  task automatic test_extreme_calibration();
    baro_cfg_t c;
    c = '1;
    c.model_select = 1'b0;
    load_calibration(c);
    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(RAW_MAX, '0);
    send_sample('0, RAW_MAX);
    c.model_select = 1'b1;
    load_calibration(c);
    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(RAW_MAX, '0);
    send_sample('0, RAW_MAX);
    c = '0;
    c.model_select = 1'b1;
    load_calibration(c);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample('0, '0);
  endtask

  task automatic test_random_phases();
    baro_cfg_t c;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      c.model_select = ph[0];
      c.sens_base = random_cal_word();
      c.off_base = random_cal_word();
      c.sens_tc = random_cal_word();
      c.off_tc = random_cal_word();
      c.ref_temp = random_cal_word();
      c.temp_coeff = random_cal_word();
      load_calibration(c);
      // first two phases run back to back
      gaps_on = (ph >= 2);
      repeat (PHASE_ITEMS) send_sample(random_pressure_count(), random_temp_count(c));
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_30bar_directed();
    test_2bar_directed();
    test_extreme_calibration();
    test_random_phases();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_readings.size() != 0) begin
      fail_count += expected_readings.size();
      $display("%0d results never arrived", expected_readings.size());
    end
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
